// File: hw/rtl/mau_pkg.sv
// package for the modular arithmetic unit: widths, command codes, sequencer states
// and the control struct of the shared modular add/sub unit; no dependencies
package mau_pkg;

  localparam int WIDTH = 32;
  localparam int CNT_W = $clog2(WIDTH);
  localparam int CMD_W = 3;
  localparam int IN_W  = CMD_W + 2 * WIDTH;
  localparam int IN_TW = ((IN_W + 7) / 8) * 8;
  localparam int OUT_TW = ((WIDTH + 7) / 8) * 8;

  localparam logic [WIDTH-1:0] MOD_RESET = WIDTH'(64'd1000000007);

  typedef enum logic [CMD_W-1:0] {
    CMD_ADD = 3'd0,
    CMD_SUB = 3'd1,
    CMD_MUL = 3'd2,
    CMD_POW = 3'd3,
    CMD_INV = 3'd4,
    CMD_DIV = 3'd5
  } cmd_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RED_A,
    ST_RED_B,
    ST_DISPATCH,
    ST_POW_CHK,
    ST_MUL_DBL,
    ST_MUL_ADD,
    ST_MUL_END,
    ST_FIN
  } state_e;

  // what a finished multiply feeds
  typedef enum logic [1:0] {
    MK_RES,
    MK_ACC,
    MK_SQR
  } mul_kind_e;

  typedef struct packed {
    logic sub;
    logic cin;
  } alu_ctl_t;

endpackage

// File: hw/rtl/mau_modalu.sv
// shared modular add/subtract unit: (x + y + cin) mod m or (x - y) mod m
// valid while the true sum stays below 2m; depends on mau_pkg
module mau_modalu (
  input  logic [mau_pkg::WIDTH-1:0] x_i,
  input  logic [mau_pkg::WIDTH-1:0] y_i,
  input  logic [mau_pkg::WIDTH-1:0] m_i,
  input  mau_pkg::alu_ctl_t         ctl_i,
  output logic [mau_pkg::WIDTH-1:0] r_o
);
  import mau_pkg::*;

  logic [WIDTH:0] sum;
  logic [WIDTH:0] sum_red;
  logic [WIDTH:0] diff;
  logic [WIDTH-1:0] diff_fix;

  assign sum      = {1'b0, x_i} + {1'b0, y_i} + {{WIDTH{1'b0}}, ctl_i.cin};
  assign sum_red  = sum - {1'b0, m_i};
  assign diff     = {1'b0, x_i} - {1'b0, y_i};
  // borrow out means negative: wrap back by adding m
  assign diff_fix = diff[WIDTH] ? (diff[WIDTH-1:0] + m_i) : diff[WIDTH-1:0];

  always_comb begin
    if (ctl_i.sub) begin
      r_o = diff_fix;
    end else if (sum >= {1'b0, m_i}) begin
      r_o = sum_red[WIDTH-1:0];
    end else begin
      r_o = sum[WIDTH-1:0];
    end
  end

endmodule

// File: hw/rtl/modular_arithmetic_unit_top.sv
// Modular arithmetic unit: add, subtract, multiply, power, Fermat inverse and divide
// modulo a configured modulus (reset 1000000007). One item is worked at a time on a
// single modular add/subtract unit: both operands are first reduced by restoring
// division, one after the other; add and subtract then finish in the dispatch state,
// and every modular multiply is double-and-add over the WIDTH multiplier bits, with
// an extra add step for each set multiplier bit. Power runs square-and-multiply over
// the exponent bits. Input ready is high only while the sequencer is idle; a
// finished result waits in the output register so the next item can be taken
// meanwhile. Write the modulus only while no item is in flight.
// depends on mau_pkg and mau_modalu
module modular_arithmetic_unit_top (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [mau_pkg::WIDTH-1:0]  cfg_wdata_i,   // modulus
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  input  logic [mau_pkg::IN_TW-1:0]  s_axis_tdata,  // cmd, operand_a, operand_b, zero fill
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  output logic [mau_pkg::OUT_TW-1:0] m_axis_tdata   // result, zero fill
);
  import mau_pkg::*;

  state_e state_q, state_d;

  logic [WIDTH-1:0] modulus_q;
  logic [CMD_W-1:0] cmd_q, cmd_d;
  logic [WIDTH-1:0] opb_q, opb_d;
  logic [WIDTH-1:0] a_q, a_d, b_q, b_d;
  logic [WIDTH-1:0] acc_q, acc_d, base_q, base_d, e_q, e_d;
  logic [WIDTH-1:0] mx_q, mx_d, my_q, my_d, macc_q, macc_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  mul_kind_e        kind_q, kind_d;
  logic             ovalid_q, ovalid_d;
  logic [WIDTH-1:0] res_q, res_d;

  logic [CMD_W-1:0] in_cmd;
  logic [WIDTH-1:0] in_a, in_b;
  logic             in_xfer;
  logic             m_zero, m_one, e_hi_zero, out_free;
  logic [WIDTH-1:0] m_minus2;

  logic [WIDTH-1:0] alu_x, alu_y, alu_r;
  alu_ctl_t         alu_ctl;

  assign in_cmd    = s_axis_tdata[CMD_W-1:0];
  assign in_a      = s_axis_tdata[CMD_W+WIDTH-1:CMD_W];
  assign in_b      = s_axis_tdata[CMD_W+2*WIDTH-1:CMD_W+WIDTH];
  assign in_xfer   = s_axis_tvalid && s_axis_tready;
  assign m_zero    = (modulus_q == '0);
  assign m_one     = (modulus_q == WIDTH'(1));
  assign m_minus2  = modulus_q - WIDTH'(2);
  assign e_hi_zero = (e_q[WIDTH-1:1] == '0);
  assign out_free  = !ovalid_q || m_axis_tready;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = OUT_TW'(res_q);

  // operand select for the shared unit
  always_comb begin
    alu_x       = (state_q == ST_DISPATCH) ? a_q : macc_q;
    alu_y       = macc_q;
    alu_ctl.sub = 1'b0;
    alu_ctl.cin = 1'b0;
    case (state_q)
      ST_DISPATCH: begin
        alu_y       = b_q;
        alu_ctl.sub = (cmd_q == CMD_SUB);
      end
      ST_MUL_ADD: alu_y = mx_q;
      ST_RED_A, ST_RED_B: alu_ctl.cin = my_q[WIDTH-1];
      default: ;
    endcase
  end

  mau_modalu u_alu (
    .x_i   (alu_x),
    .y_i   (alu_y),
    .m_i   (modulus_q),
    .ctl_i (alu_ctl),
    .r_o   (alu_r)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          if (m_zero || (in_cmd > CMD_DIV)) begin
            state_d = ST_FIN;
          end else begin
            state_d = ST_RED_A;
          end
        end
      end
      ST_RED_A: if (cnt_q == '0) state_d = ST_RED_B;
      ST_RED_B: if (cnt_q == '0) state_d = ST_DISPATCH;
      ST_DISPATCH: begin
        case (cmd_q)
          CMD_MUL: state_d = ST_MUL_DBL;
          CMD_POW: state_d = (opb_q == '0) ? ST_FIN : ST_POW_CHK;
          CMD_INV, CMD_DIV: state_d = m_one ? ST_FIN : ST_POW_CHK;
          default: state_d = ST_FIN;
        endcase
      end
      ST_POW_CHK: begin
        if (e_q != '0) begin
          state_d = ST_MUL_DBL;
        end else if (cmd_q == CMD_DIV) begin
          state_d = ST_MUL_DBL;
        end else begin
          state_d = ST_FIN;
        end
      end
      ST_MUL_DBL: begin
        if (my_q[WIDTH-1]) begin
          state_d = ST_MUL_ADD;
        end else if (cnt_q == '0) begin
          state_d = ST_MUL_END;
        end
      end
      ST_MUL_ADD: state_d = (cnt_q == '0) ? ST_MUL_END : ST_MUL_DBL;
      ST_MUL_END: begin
        case (kind_q)
          MK_RES: state_d = ST_FIN;
          MK_ACC: state_d = e_hi_zero ? ST_POW_CHK : ST_MUL_DBL;
          default: state_d = ST_POW_CHK;
        endcase
      end
      ST_FIN: if (out_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // datapath updates
  always_comb begin
    cmd_d    = cmd_q;
    opb_d    = opb_q;
    a_d      = a_q;
    b_d      = b_q;
    acc_d    = acc_q;
    base_d   = base_q;
    e_d      = e_q;
    mx_d     = mx_q;
    my_d     = my_q;
    macc_d   = macc_q;
    cnt_d    = cnt_q;
    kind_d   = kind_q;
    ovalid_d = ovalid_q;
    res_d    = res_q;

    if (ovalid_q && m_axis_tready) ovalid_d = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          cmd_d  = in_cmd;
          opb_d  = in_b;
          my_d   = in_a;
          macc_d = '0;
          cnt_d  = CNT_W'(WIDTH - 1);
        end
      end
      ST_RED_A, ST_RED_B: begin
        macc_d = alu_r;
        my_d   = my_q << 1;
        cnt_d  = cnt_q - CNT_W'(1);
        if (cnt_q == '0) begin
          if (state_q == ST_RED_A) begin
            a_d    = alu_r;
            macc_d = '0;
            my_d   = opb_q;
            cnt_d  = CNT_W'(WIDTH - 1);
          end else begin
            b_d = alu_r;
          end
        end
      end
      ST_DISPATCH: begin
        acc_d = WIDTH'(1);
        e_d   = m_minus2;
        case (cmd_q)
          CMD_ADD, CMD_SUB: macc_d = alu_r;
          CMD_MUL: begin
            mx_d   = a_q;
            my_d   = b_q;
            macc_d = '0;
            cnt_d  = CNT_W'(WIDTH - 1);
            kind_d = MK_RES;
          end
          CMD_POW: begin
            macc_d = WIDTH'(1);
            acc_d  = m_one ? '0 : WIDTH'(1);
            base_d = a_q;
            e_d    = opb_q;
          end
          CMD_INV: begin
            macc_d = '0;
            base_d = a_q;
          end
          default: begin
            macc_d = '0;
            base_d = b_q;
          end
        endcase
      end
      ST_POW_CHK: begin
        macc_d = '0;
        cnt_d  = CNT_W'(WIDTH - 1);
        if (e_q == '0) begin
          mx_d   = a_q;
          my_d   = acc_q;
          kind_d = MK_RES;
          if (cmd_q != CMD_DIV) macc_d = acc_q;
        end else if (e_q[0]) begin
          mx_d   = acc_q;
          my_d   = base_q;
          kind_d = MK_ACC;
        end else begin
          mx_d   = base_q;
          my_d   = base_q;
          kind_d = MK_SQR;
        end
      end
      ST_MUL_DBL: begin
        macc_d = alu_r;
        if (!my_q[WIDTH-1] && (cnt_q != '0)) begin
          my_d  = my_q << 1;
          cnt_d = cnt_q - CNT_W'(1);
        end
      end
      ST_MUL_ADD: begin
        macc_d = alu_r;
        if (cnt_q != '0) begin
          my_d  = my_q << 1;
          cnt_d = cnt_q - CNT_W'(1);
        end
      end
      ST_MUL_END: begin
        case (kind_q)
          MK_ACC: begin
            acc_d = macc_q;
            if (e_hi_zero) begin
              e_d = '0;
            end else begin
              mx_d   = base_q;
              my_d   = base_q;
              macc_d = '0;
              cnt_d  = CNT_W'(WIDTH - 1);
              kind_d = MK_SQR;
            end
          end
          MK_SQR: begin
            base_d = macc_q;
            e_d    = e_q >> 1;
          end
          default: ;
        endcase
      end
      ST_FIN: begin
        if (out_free) begin
          ovalid_d = 1'b1;
          res_d    = macc_q;
        end
      end
      default: ;
    endcase

    // unused commands and a zero modulus give zero
    if ((state_q == ST_IDLE) && in_xfer) macc_d = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      modulus_q <= MOD_RESET;
      ovalid_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      ovalid_q <= ovalid_d;
      if (cfg_we_i) modulus_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q  <= cmd_d;
    opb_q  <= opb_d;
    a_q    <= a_d;
    b_q    <= b_d;
    acc_q  <= acc_d;
    base_q <= base_d;
    e_q    <= e_d;
    mx_q   <= mx_d;
    my_q   <= my_d;
    macc_q <= macc_d;
    cnt_q  <= cnt_d;
    kind_q <= kind_d;
    res_q  <= res_d;
  end

endmodule

// File: hw/rtl/mau_checker.sv
// port-level checks for the modular arithmetic unit, bound to the top level
// depends on mau_pkg
module mau_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       s_axis_tvalid,
  input logic                       s_axis_tready,
  input logic                       m_axis_tvalid,
  input logic                       m_axis_tready,
  input logic [mau_pkg::OUT_TW-1:0] m_axis_tdata
);
  import mau_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed or dropped while stalled");

  // an accepted transfer makes the unit busy
  a_busy_after_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input ready stayed high after a transfer");

  // a new result only comes out of a busy unit
  a_res_from_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> !$past(s_axis_tready))
    else $error("result appeared without work in flight");

  // the unit is idle again once a result is posted
  a_idle_after_res: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> s_axis_tready)
    else $error("unit not idle after posting a result");

endmodule

bind modular_arithmetic_unit_top mau_checker u_mau_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

// File: bench/tb_top.sv
// self-checking bench for modular_arithmetic_unit_top: directed corner items, then
// random command mixes under a series of modulus settings; depends on mau_pkg and the rtl
module tb_top;
  import mau_pkg::*;

  localparam logic [CMD_W-1:0] CMD_RSVD_6 = 3'd6;
  localparam logic [CMD_W-1:0] CMD_RSVD_7 = 3'd7;
  localparam int NUM_PHASES     = 12;
  localparam int WATCHDOG_LIMIT = 40000;
  localparam int TAIL_CYCLES    = 100;

  typedef struct {
    logic [CMD_W-1:0] cmd;
    logic [WIDTH-1:0] opa;
    logic [WIDTH-1:0] opb;
  } mau_op_t;

  typedef struct {
    logic [WIDTH-1:0] residue;
    mau_op_t          op;
    logic [WIDTH-1:0] modv;
  } residue_exp_t;

  logic              clk_i;
  logic              rst_ni        = 1'b0;
  logic              cfg_we_i      = 1'b0;
  logic [WIDTH-1:0]  cfg_wdata_i   = '0;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [IN_TW-1:0]  s_axis_tdata  = '0;
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [OUT_TW-1:0] m_axis_tdata;

  mau_op_t      pending_ops[$];
  residue_exp_t residue_q[$];
  logic [WIDTH-1:0] cur_modulus = MOD_RESET;

  int n_queued = 0;
  int n_taken = 0;
  int n_checked = 0;
  int n_fail = 0;
  int quiet_cycles = 0;
  int src_idle_pct = 0;
  int snk_idle_pct = 0;
  int src_hold = 0;
  int snk_hold = 0;
  int cmd_seen[8] = '{default: 0};
  bit in_fire = 1'b0;
  bit out_fire = 1'b0;

  modular_arithmetic_unit_top i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  // operands stay below 2^32, so a 64-bit product never overflows
  function automatic logic [63:0] mul_residue(logic [63:0] x, logic [63:0] y, logic [63:0] m);
    return (x * y) % m;
  endfunction

  function automatic logic [63:0] pow_residue(logic [63:0] base, logic [63:0] e,
                                              logic [63:0] m);
    logic [63:0] acc;
    if (e == 0) return 64'd1;
    acc = 64'd1 % m;
    while (e != 0) begin
      if (e[0]) acc = mul_residue(acc, base, m);
      base = mul_residue(base, base, m);
      e = e >> 1;
    end
    return acc;
  endfunction

  function automatic logic [WIDTH-1:0] predict_residue(mau_op_t op, logic [WIDTH-1:0] modv);
    logic [63:0] m;
    logic [63:0] a;
    logic [63:0] b;
    logic [63:0] r;
    m = modv;
    if (m == 0) return '0;
    a = op.opa % m;
    b = op.opb % m;
    case (op.cmd)
      CMD_ADD: r = (a + b) % m;
      CMD_SUB: r = (a >= b) ? a - b : a + (m - b);
      CMD_MUL: r = mul_residue(a, b, m);
      // power by zero is 1 even when the modulus is one
      CMD_POW: r = (op.opb == 0) ? 64'd1 : pow_residue(a, op.opb, m);
      CMD_INV: r = (m < 2) ? 64'd0 : pow_residue(a, m - 2, m);
      CMD_DIV: r = (m < 2) ? 64'd0 : mul_residue(a, pow_residue(b, m - 2, m) % m, m);
      default: r = 64'd0;
    endcase
    return r[WIDTH-1:0];
  endfunction

  function automatic logic [WIDTH-1:0] pick_operand(logic [WIDTH-1:0] modv);
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2: return modv - 1'b1;
      3: return modv;
      4: return modv + 1'b1;
      5: return WIDTH'($urandom_range(0, 15));
      6: return (modv == 0) ? WIDTH'($urandom) : WIDTH'($urandom % modv);
      default: return WIDTH'($urandom);
    endcase
  endfunction

  // mostly short exponents keep power runs cheap; some take all the bits
  function automatic logic [WIDTH-1:0] pick_exponent();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2: return WIDTH'($urandom);
      default: return WIDTH'($urandom) & ((WIDTH'(1) << $urandom_range(1, 10)) - 1'b1);
    endcase
  endfunction

  task automatic queue_op(logic [CMD_W-1:0] cmd, logic [WIDTH-1:0] opa, logic [WIDTH-1:0] opb);
    mau_op_t op;
    op.cmd = cmd;
    op.opa = opa;
    op.opb = opb;
    pending_ops.insert(pending_ops.size(), op);
    n_queued++;
  endtask

  task automatic queue_random_op();
    int sel;
    logic [CMD_W-1:0] cmd;
    logic [WIDTH-1:0] opb;
    sel = $urandom_range(0, 99);
    if (sel < 20) cmd = CMD_ADD;
    else if (sel < 40) cmd = CMD_SUB;
    else if (sel < 60) cmd = CMD_MUL;
    else if (sel < 75) cmd = CMD_POW;
    else if (sel < 82) cmd = CMD_INV;
    else if (sel < 92) cmd = CMD_DIV;
    else cmd = ($urandom_range(0, 1) != 0) ? CMD_RSVD_7 : CMD_RSVD_6;
    opb = (cmd == CMD_POW) ? pick_exponent() : pick_operand(cur_modulus);
    queue_op(cmd, pick_operand(cur_modulus), opb);
  endtask

  // sampled at the falling edge, where monitor counters are settled
  task automatic wait_drained();
    do @(negedge clk_i); while (n_taken != n_queued || residue_q.size() != 0);
  endtask

  task automatic write_modulus(logic [WIDTH-1:0] value);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    cur_modulus = value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic queue_directed(int ph);
    case (ph)
      0: begin
        queue_op(CMD_ADD, '1, '1);
        queue_op(CMD_ADD, '0, '0);
        queue_op(CMD_SUB, 32'd0, 32'd1);
        queue_op(CMD_SUB, 32'd5, MOD_RESET + 32'd9);
        queue_op(CMD_MUL, '1, '1);
        queue_op(CMD_MUL, MOD_RESET - 1'b1, MOD_RESET - 1'b1);
        queue_op(CMD_POW, 32'd0, 32'd0);
        queue_op(CMD_POW, 32'd12345, 32'd0);
        queue_op(CMD_POW, '1, '1);
        queue_op(CMD_POW, 32'd2, 32'd10);
        queue_op(CMD_INV, 32'd0, 32'd3);
        queue_op(CMD_INV, 32'd2, '1);
        queue_op(CMD_DIV, 32'd10, 32'd3);
        queue_op(CMD_DIV, 32'd7, MOD_RESET);
        queue_op(CMD_RSVD_6, '1, '1);
        queue_op(CMD_RSVD_7, 32'd1, 32'd1);
      end
      1: begin
        // modulus two: inverse collapses to 1, divide to a mod 2
        queue_op(CMD_INV, 32'd5, 32'd0);
        queue_op(CMD_DIV, '1, 32'd3);
        queue_op(CMD_POW, 32'd0, 32'd0);
      end
      2: begin
        queue_op(CMD_POW, 32'd7, 32'd0);
        queue_op(CMD_ADD, 32'd3, 32'd4);
        queue_op(CMD_INV, 32'd9, 32'd0);
      end
      3: begin
        queue_op(CMD_MUL, 32'd3, 32'd4);
        queue_op(CMD_POW, 32'd3, 32'd0);
        queue_op(CMD_DIV, 32'd9, 32'd9);
      end
      default: ;
    endcase
  endtask

  // source side: hold tvalid until the transfer, then idle in bursts or present the next op
  always @(negedge clk_i) begin : source_driver
    mau_op_t op;
    if (rst_ni && (!s_axis_tvalid || in_fire)) begin
      if (src_hold > 0) begin
        src_hold--;
        s_axis_tvalid <= 1'b0;
      end else if (src_idle_pct > 0 && $urandom_range(0, 99) < src_idle_pct) begin
        src_hold = $urandom_range(1, 18) - 1;
        s_axis_tvalid <= 1'b0;
      end else if (pending_ops.size() != 0) begin
        op = pending_ops.pop_front();
        s_axis_tdata  <= {{(IN_TW - IN_W){1'b0}}, op.opb, op.opa, op.cmd};
        s_axis_tvalid <= 1'b1;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin : sink_driver
    if (rst_ni) begin
      if (snk_hold > 0) begin
        snk_hold--;
        m_axis_tready <= 1'b0;
      end else if (snk_idle_pct > 0 && $urandom_range(0, 99) < snk_idle_pct) begin
        snk_hold = $urandom_range(1, 18) - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin : monitor
    residue_exp_t want;
    mau_op_t op;
    logic [WIDTH-1:0] got;
    in_fire  = 1'b0;
    out_fire = 1'b0;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        in_fire = 1'b1;
        op.cmd = s_axis_tdata[CMD_W-1:0];
        op.opa = s_axis_tdata[CMD_W +: WIDTH];
        op.opb = s_axis_tdata[CMD_W + WIDTH +: WIDTH];
        want.op      = op;
        want.modv    = cur_modulus;
        want.residue = predict_residue(op, cur_modulus);
        residue_q.insert(residue_q.size(), want);
        cmd_seen[op.cmd]++;
        n_taken++;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        out_fire = 1'b1;
        got = m_axis_tdata[WIDTH-1:0];
        if (residue_q.size() == 0) begin
          $error("result: nothing expected, actual 0x%08h", got);
          n_fail++;
        end else begin
          want = residue_q.pop_front();
          n_checked++;
          if (got !== want.residue) begin
            $error("result: expected 0x%08h, actual 0x%08h (cmd %0d a 0x%08h b 0x%08h m 0x%08h)",
                   want.residue, got, want.op.cmd, want.op.opa, want.op.opb, want.modv);
            n_fail++;
          end
        end
      end
      if (in_fire || out_fire) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("timeout: no transfer for %0d cycles", WATCHDOG_LIMIT);
        $display("modular_arithmetic_unit_top test failed");
        $finish;
      end
    end
  end

  initial begin : stimulus
    logic [WIDTH-1:0] mod_plan[NUM_PHASES];
    int random_ops[NUM_PHASES];
    mod_plan = '{MOD_RESET, 32'd2, 32'd1, 32'd0, 32'd3, 32'hFFFF_FFFB, 32'hFFFF_FFFF,
                 32'd65521, WIDTH'($urandom_range(4, 5000)), 32'h8000_0000,
                 WIDTH'($urandom) | 32'h8000_0000, MOD_RESET};
    random_ops = '{170, 120, 40, 40, 150, 170, 170, 170, 170, 150, 170, 170};
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      wait_drained();
      // the first phase runs on the reset value of the modulus
      if (ph != 0) write_modulus(mod_plan[ph]);
      @(posedge clk_i);
      src_idle_pct = (ph == NUM_PHASES - 1) ? 0 : 10 * $urandom_range(0, 3);
      snk_idle_pct = (ph == NUM_PHASES - 1) ? 0 : 10 * $urandom_range(0, 3);
      queue_directed(ph);
      for (int k = 0; k < random_ops[ph]; k++) begin
        // hold the source back once until every result is in
        if (ph == 5 && k == random_ops[ph] / 2) begin
          wait_drained();
          @(posedge clk_i);
        end
        queue_random_op();
      end
    end
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (residue_q.size() != 0) begin
      $error("result: %0d expected values never arrived", residue_q.size());
      n_fail++;
    end
    $display("checked %0d results over %0d modulus settings", n_checked, NUM_PHASES);
    $display("ops: add %0d sub %0d mul %0d pow %0d inv %0d div %0d unused %0d",
             cmd_seen[CMD_ADD], cmd_seen[CMD_SUB], cmd_seen[CMD_MUL], cmd_seen[CMD_POW],
             cmd_seen[CMD_INV], cmd_seen[CMD_DIV], cmd_seen[CMD_RSVD_6] + cmd_seen[CMD_RSVD_7]);
    if (n_fail == 0) begin
      $display("modular_arithmetic_unit_top test passed");
    end else begin
      $display("modular_arithmetic_unit_top test failed");
    end
    $finish;
  end

endmodule

// File: filelist.f
hw/rtl/mau_pkg.sv
hw/rtl/mau_modalu.sv
hw/rtl/modular_arithmetic_unit_top.sv
hw/rtl/mau_checker.sv
bench/tb_top.sv
